@@ hdl/assert_macros.svh @@
// Assertion macros shared by the stack machine RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Assert implication on every edge outside reset
`define SMX_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert implication including reset cycles
`define SMX_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SMX_ASSERT(label, clk, rst_n, prop, msg)
`define SMX_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ hdl/smx_pkg.sv @@
// Package: opcodes, status codes and defaults for the stack machine executor
package smx_pkg;
  localparam int unsigned DataDepthDef = 256;
  localparam int unsigned CallDepthDef = 1024;
  localparam int unsigned AddrBitsDef  = 16;
  localparam int unsigned CmdW    = 5;
  localparam int unsigned StatusW = 4;
  localparam int unsigned CellW   = 32;
  localparam int unsigned DepthW  = 9;
  localparam int unsigned InAddrW = 16;
  localparam int unsigned ImmLen  = 5;

  localparam logic [CmdW-1:0] OP_HALT = 5'd0,  OP_PUSH = 5'd1,  OP_POP  = 5'd2;
  localparam logic [CmdW-1:0] OP_DUP  = 5'd3,  OP_SWAP = 5'd4,  OP_ROT  = 5'd5;
  localparam logic [CmdW-1:0] OP_ADD  = 5'd6,  OP_SUB  = 5'd7,  OP_MUL  = 5'd8;
  localparam logic [CmdW-1:0] OP_DIV  = 5'd9,  OP_MOD  = 5'd10, OP_BAND = 5'd11;
  localparam logic [CmdW-1:0] OP_BOR  = 5'd12, OP_BNOT = 5'd13, OP_BXOR = 5'd14;
  localparam logic [CmdW-1:0] OP_LAND = 5'd15, OP_LOR  = 5'd16, OP_LNOT = 5'd17;
  localparam logic [CmdW-1:0] OP_LXOR = 5'd18, OP_JMP  = 5'd19, OP_BR   = 5'd20;
  localparam logic [CmdW-1:0] OP_CALL = 5'd21, OP_RET  = 5'd22;

  localparam logic [StatusW-1:0] ST_OK    = 4'd0, ST_HALT = 4'd1, ST_DUF = 4'd2;
  localparam logic [StatusW-1:0] ST_DOF   = 4'd3, ST_IMM  = 4'd4, ST_OFF = 4'd5;
  localparam logic [StatusW-1:0] ST_COF   = 4'd6, ST_CUF  = 4'd7, ST_UNDEF = 4'd8;
  localparam logic [StatusW-1:0] ST_DIV0  = 4'd9;
endpackage

@@ hdl/stack_machine_executor_unit.sv @@
// Stack machine executor: one instruction per transaction, stacks in block memory
// Steps: decode, stack reads, execute, stack writes, top read and output; an error skips
// the later writes, return reads the call stack in place of the writes, and divide and
// modulo first run the shared 1-bit-per-cycle divider (32 steps). A new transaction is
// taken while a result waits; a stalled result holds the following one in its output step.
// Synchronous active-low reset clears counts, sequencer and the length register to 65535.
`include "assert_macros.svh"
module stack_machine_executor_unit #(
  parameter int unsigned DATA_DEPTH = smx_pkg::DataDepthDef,
  parameter int unsigned CALL_DEPTH = smx_pkg::CallDepthDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [15:0]                       cfg_program_length,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [smx_pkg::CmdW-1:0]          in_cmd,
  input  logic signed [smx_pkg::CellW-1:0]  in_immediate,
  input  logic [smx_pkg::InAddrW-1:0]       in_instr_addr,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [smx_pkg::StatusW-1:0]       out_status,
  output logic [smx_pkg::InAddrW-1:0]       out_next_addr,
  output logic signed [smx_pkg::CellW-1:0]  out_top_value,
  output logic [smx_pkg::DepthW-1:0]        out_stack_depth
);
  localparam int unsigned DAW = $clog2(DATA_DEPTH);
  localparam int unsigned CAW = $clog2(CALL_DEPTH);
  localparam int unsigned DCW = $clog2(DATA_DEPTH + 1);
  localparam int unsigned CCW = $clog2(CALL_DEPTH + 1);
  localparam int unsigned CW  = smx_pkg::CellW;
  localparam int unsigned AW  = smx_pkg::AddrBitsDef;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_RD1 = 4'd2, S_RD2 = 4'd3;
  localparam logic [3:0] S_RD3 = 4'd4, S_EXE = 4'd5, S_DIV = 4'd6, S_DFIN = 4'd7;
  localparam logic [3:0] S_WR1 = 4'd8, S_WR2 = 4'd9, S_WR3 = 4'd10, S_TOP = 4'd11;
  localparam logic [3:0] S_TOPW = 4'd12, S_OUT = 4'd13, S_CRD = 4'd14, S_CRDW = 4'd15;

  logic [3:0]          state_r, state_nxt;
  logic [15:0]         plen_r;
  logic [DCW-1:0]      dcnt_r;
  logic [CCW-1:0]      ccnt_r;
  logic [smx_pkg::CmdW-1:0] op_r;
  logic [CW-1:0]       imm_r;
  logic [AW-1:0]       addr_r;
  logic [CW-1:0]       a_r, b_r, c_r;
  logic [smx_pkg::StatusW-1:0] st_r;
  logic [AW-1:0]       next_r;
  logic [5:0]          step_r;
  logic                st_ok;
  logic                div_go;
  logic                out_load;

  // Divider state
  logic [CW-1:0]       quo_r, rem_r, dvs_r;
  logic                neg_q_r, neg_r_r;

  // Memories
  logic [CW-1:0]       dmem [DATA_DEPTH];
  logic [AW-1:0]       cmem [CALL_DEPTH];
  logic [CW-1:0]       drd_r;
  logic [AW-1:0]       crd_r;
  logic                dwe;
  logic [DAW-1:0]      dwa, dra;
  logic [CW-1:0]       dwd;

  // Output register
  logic                ov_r;
  logic [smx_pkg::StatusW-1:0] ost_r;
  logic [AW-1:0]       onext_r;
  logic [CW-1:0]       otop_r;
  logic [DCW-1:0]      odep_r;

  // Address arithmetic
  logic [AW:0]         after_imm;
  logic signed [CW+1:0] target;
  logic                imm_missing, bad_target;
  logic                is_bin;

  assign after_imm   = {1'b0, addr_r} + (AW+1)'(smx_pkg::ImmLen);
  assign target      = $signed({(CW+1-AW)'(0), after_imm}) + $signed({{2{imm_r[CW-1]}}, imm_r});
  assign imm_missing = after_imm > {1'b0, plen_r};
  assign bad_target  = target[CW+1] || (target >= $signed((CW+2)'(plen_r)));
  assign is_bin = (op_r == smx_pkg::OP_ADD) || (op_r == smx_pkg::OP_SUB) ||
                  (op_r == smx_pkg::OP_MUL) || (op_r == smx_pkg::OP_DIV) ||
                  (op_r == smx_pkg::OP_MOD) || (op_r == smx_pkg::OP_BAND) ||
                  (op_r == smx_pkg::OP_BOR) || (op_r == smx_pkg::OP_BXOR) ||
                  (op_r == smx_pkg::OP_LAND) || (op_r == smx_pkg::OP_LOR) ||
                  (op_r == smx_pkg::OP_LXOR);
  assign st_ok  = (st_r == smx_pkg::ST_OK);
  assign div_go = st_ok && (a_r != '0) &&
                  (op_r == smx_pkg::OP_DIV || op_r == smx_pkg::OP_MOD);
  assign out_load = (state_r == S_OUT) && (!ov_r || !out_stall);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_next_addr = onext_r;
  assign out_top_value = $signed(otop_r);
  assign out_stack_depth = smx_pkg::DepthW'(odep_r);

  // Stack index helpers
  function automatic logic [DAW-1:0] didx(input logic [DCW-1:0] cnt, input int unsigned k);
    logic [DCW:0] v;
    v = {1'b0, cnt} - (DCW+1)'(k);
    return v[DAW-1:0];
  endfunction

  // Data memory
  always_ff @(posedge clk) begin
    if (dwe) begin
      dmem[dwa] <= dwd;
    end
    drd_r <= dmem[dra];
  end

  // Call memory: push only for a call that passes every check
  always_ff @(posedge clk) begin
    if (state_r == S_DEC && op_r == smx_pkg::OP_CALL && ccnt_r < CCW'(CALL_DEPTH) &&
        !imm_missing && !bad_target) begin
      cmem[ccnt_r[CAW-1:0]] <= after_imm[AW-1:0];
    end
    crd_r <= cmem[ccnt_r[CAW-1:0]];
  end

  // Data memory read address and write port
  always_comb begin
    dra = didx(dcnt_r, 1);
    dwe = 1'b0;
    dwa = didx(dcnt_r, 1);
    dwd = a_r;
    unique case (state_r)
      S_RD1: dra = didx(dcnt_r, 1);
      S_RD2: dra = didx(dcnt_r, 2);
      S_RD3: dra = didx(dcnt_r, 3);
      S_WR1: begin
        priority case (op_r)
          smx_pkg::OP_PUSH: begin dwe = st_ok; dwa = dcnt_r[DAW-1:0]; dwd = imm_r; end
          smx_pkg::OP_DUP:  begin dwe = st_ok; dwa = dcnt_r[DAW-1:0]; dwd = a_r; end
          smx_pkg::OP_BNOT, smx_pkg::OP_LNOT: begin
            dwe = st_ok; dwa = didx(dcnt_r, 1); dwd = c_r;
          end
          smx_pkg::OP_SWAP: begin dwe = st_ok; dwa = didx(dcnt_r, 1); dwd = b_r; end
          smx_pkg::OP_ROT:  begin dwe = st_ok; dwa = didx(dcnt_r, 1); dwd = c_r; end
          default:          begin dwe = st_ok && is_bin; dwa = didx(dcnt_r, 2); dwd = c_r; end
        endcase
      end
      S_WR2: begin
        dwe = st_ok && (op_r == smx_pkg::OP_SWAP || op_r == smx_pkg::OP_ROT);
        dwa = didx(dcnt_r, 2);
        dwd = a_r;
      end
      S_WR3: begin
        dwe = st_ok && (op_r == smx_pkg::OP_ROT);
        dwa = didx(dcnt_r, 3);
        dwd = b_r;
      end
      S_TOP: dra = didx(dcnt_r, 1);
      default: ;
    endcase
  end

  // Sequencer transitions
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid && !in_stall) state_nxt = S_DEC;
      S_DEC:  state_nxt = S_RD1;
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  state_nxt = S_RD3;
      S_RD3:  state_nxt = S_EXE;
      S_EXE: begin
        if (div_go) state_nxt = S_DIV;
        else if (st_ok && op_r == smx_pkg::OP_RET) state_nxt = S_CRD;
        else state_nxt = S_WR1;
      end
      S_DIV:  if (step_r == 6'd31) state_nxt = S_DFIN;
      S_DFIN: state_nxt = S_WR1;
      S_WR1:  state_nxt = st_ok ? S_WR2 : S_TOP;
      S_WR2:  state_nxt = S_WR3;
      S_WR3:  state_nxt = S_TOP;
      S_TOP:  state_nxt = S_TOPW;
      S_TOPW: state_nxt = S_OUT;
      S_OUT:  if (!ov_r || !out_stall) state_nxt = S_IDLE;
      S_CRD:  state_nxt = S_CRDW;
      S_CRDW: state_nxt = S_TOP;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Divider trial subtract
  logic [CW:0] trial;
  assign trial = {rem_r, quo_r[CW-1]} - {1'b0, dvs_r};

  // Datapath and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      plen_r  <= 16'hFFFF;
      dcnt_r  <= '0;
      ccnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) plen_r <= cfg_program_length;
      // Load a finished result, or drop the one taken downstream
      if (out_load) begin
        ov_r    <= 1'b1;
        ost_r   <= st_r;
        onext_r <= st_ok ? next_r : addr_r;
        otop_r  <= (dcnt_r == '0) ? '0 : drd_r;
        odep_r  <= dcnt_r;
      end else if (ov_r && !out_stall) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op_r   <= in_cmd;
            imm_r  <= in_immediate;
            addr_r <= in_instr_addr;
            next_r <= in_instr_addr + AW'(1);
            st_r   <= smx_pkg::ST_OK;
          end
        end
        S_DEC: begin
          priority case (op_r)
            smx_pkg::OP_HALT: st_r <= smx_pkg::ST_HALT;
            smx_pkg::OP_PUSH:
              if (dcnt_r >= DCW'(DATA_DEPTH)) st_r <= smx_pkg::ST_DOF;
              else if (imm_missing) st_r <= smx_pkg::ST_IMM;
              else next_r <= after_imm[AW-1:0];
            smx_pkg::OP_POP, smx_pkg::OP_BNOT, smx_pkg::OP_LNOT:
              if (dcnt_r < DCW'(1)) st_r <= smx_pkg::ST_DUF;
            smx_pkg::OP_DUP:
              if (dcnt_r < DCW'(1)) st_r <= smx_pkg::ST_DUF;
              else if (dcnt_r >= DCW'(DATA_DEPTH)) st_r <= smx_pkg::ST_DOF;
            smx_pkg::OP_SWAP:
              if (dcnt_r < DCW'(2)) st_r <= smx_pkg::ST_DUF;
            smx_pkg::OP_ROT:
              if (dcnt_r < DCW'(3)) st_r <= smx_pkg::ST_DUF;
            smx_pkg::OP_JMP:
              if (imm_missing) st_r <= smx_pkg::ST_IMM;
              else if (bad_target) st_r <= smx_pkg::ST_OFF;
              else next_r <= target[AW-1:0];
            smx_pkg::OP_BR:
              if (dcnt_r < DCW'(1)) st_r <= smx_pkg::ST_DUF;
              else if (imm_missing) st_r <= smx_pkg::ST_IMM;
            smx_pkg::OP_CALL:
              if (ccnt_r >= CCW'(CALL_DEPTH)) st_r <= smx_pkg::ST_COF;
              else if (imm_missing) st_r <= smx_pkg::ST_IMM;
              else if (bad_target) st_r <= smx_pkg::ST_OFF;
              else begin
                next_r <= target[AW-1:0];
                ccnt_r <= ccnt_r + CCW'(1);
              end
            smx_pkg::OP_RET:
              if (ccnt_r == '0) st_r <= smx_pkg::ST_CUF;
            default:
              if (is_bin) begin
                if (dcnt_r < DCW'(2)) st_r <= smx_pkg::ST_DUF;
              end else st_r <= smx_pkg::ST_UNDEF;
          endcase
        end
        S_RD2: a_r <= drd_r;
        S_RD3: b_r <= drd_r;
        S_EXE: begin
          if (op_r == smx_pkg::OP_RET && st_r == smx_pkg::ST_OK) begin
            ccnt_r <= ccnt_r - CCW'(1);
          end
          if (st_r != smx_pkg::ST_OK) begin
            // nothing to write on error
          end else begin
            priority case (op_r)
              smx_pkg::OP_BNOT: c_r <= ~a_r;
              smx_pkg::OP_LNOT: c_r <= (a_r == '0) ? CW'(1) : '0;
              smx_pkg::OP_ADD:  c_r <= b_r + a_r;
              smx_pkg::OP_SUB:  c_r <= b_r - a_r;
              smx_pkg::OP_MUL:  c_r <= b_r * a_r;
              smx_pkg::OP_BAND: c_r <= b_r & a_r;
              smx_pkg::OP_BOR:  c_r <= b_r | a_r;
              smx_pkg::OP_BXOR: c_r <= b_r ^ a_r;
              smx_pkg::OP_LAND: c_r <= CW'((b_r != '0) && (a_r != '0));
              smx_pkg::OP_LOR:  c_r <= CW'((b_r != '0) || (a_r != '0));
              smx_pkg::OP_LXOR: c_r <= CW'((b_r != '0) != (a_r != '0));
              smx_pkg::OP_ROT:  c_r <= drd_r;
              default: ;
            endcase
            if ((op_r == smx_pkg::OP_DIV || op_r == smx_pkg::OP_MOD) && a_r == '0) begin
              st_r <= smx_pkg::ST_DIV0;
            end
            if (op_r == smx_pkg::OP_BR) begin
              if (a_r == '0) begin
                next_r <= after_imm[AW-1:0];
              end else if (bad_target) begin
                st_r <= smx_pkg::ST_OFF;
              end else begin
                next_r <= target[AW-1:0];
              end
            end
          end
        end
        S_DIV: begin
          if (!trial[CW]) rem_r <= trial[CW-1:0];
          else rem_r <= {rem_r[CW-2:0], quo_r[CW-1]};
          quo_r  <= {quo_r[CW-2:0], ~trial[CW]};
          step_r <= step_r + 6'd1;
        end
        S_DFIN: begin
          if (op_r == smx_pkg::OP_DIV) c_r <= neg_q_r ? -quo_r : quo_r;
          else c_r <= neg_r_r ? -rem_r : rem_r;
        end
        S_WR3: begin
          if (st_r == smx_pkg::ST_OK) begin
            priority case (op_r)
              smx_pkg::OP_PUSH, smx_pkg::OP_DUP: dcnt_r <= dcnt_r + DCW'(1);
              smx_pkg::OP_POP, smx_pkg::OP_BR:   dcnt_r <= dcnt_r - DCW'(1);
              default: if (is_bin) dcnt_r <= dcnt_r - DCW'(1);
            endcase
          end
        end
        S_CRDW: next_r <= crd_r;
        default: ;
      endcase
      // Divider start: operands a (divisor) and b (dividend) from the stack
      if (state_r == S_EXE && div_go) begin
        step_r  <= '0;
        rem_r   <= '0;
        quo_r   <= b_r[CW-1] ? -b_r : b_r;
        dvs_r   <= a_r[CW-1] ? -a_r : a_r;
        neg_q_r <= b_r[CW-1] ^ a_r[CW-1];
        neg_r_r <= b_r[CW-1];
      end
    end
  end

  `SMX_ASSERT(a_out_hold, clk, rst_n, ov_r && out_stall |=> ov_r, "result dropped while stalled")
  `SMX_ASSERT(a_no_accept_busy, clk, rst_n, state_r != S_IDLE |-> in_stall, "accepted while busy")
  `SMX_ASSERT(a_depth_bound, clk, rst_n, dcnt_r <= DCW'(DATA_DEPTH), "data depth overrun")
  `SMX_ASSERT(a_call_bound, clk, rst_n, ccnt_r <= CCW'(CALL_DEPTH), "call depth overrun")
endmodule
